@@ hdl/tskf_pkg.sv @@
// Shared widths, register indexes, reset values and unit request types of the Kalman fusion unit.
package tskf_pkg;

  // Sample and state formats
  localparam int SAMPLE_W     = 16;                 // signed Q8.8 sample
  localparam int SAMPLE_SHIFT = 8;                  // Q8.8 to Q16.16
  localparam int EST_W        = 32;                 // signed Q16.16 estimate
  localparam int Q_W          = 16;                 // unsigned Q1.15 quantities
  localparam int FRAC_B       = 15;
  localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * Q_W;

  // Datapath widths
  localparam int DEN_W   = Q_W + 2;                 // covariance + noise*trust
  localparam int INNOV_W = ((SAMPLE_W + SAMPLE_SHIFT > EST_W) ?
                            SAMPLE_W + SAMPLE_SHIFT : EST_W) + 1;
  localparam int MC_W    = INNOV_W + 2;             // multiplicand of the serial multiplier
  localparam int MUL_OPW = Q_W;                     // multiplier operand, consumed by digits
  localparam int MUL_DIG = 4;                       // bits per multiplier digit
  localparam int MUL_STEPS = MUL_OPW / MUL_DIG;
  localparam int PROD_W  = MC_W + MUL_OPW;
  localparam int DIV_STEPS = FRAC_B;                // quotient bits below 1.0

  // Output clamp bounds for the sample width
  localparam logic signed [EST_W-1:0] OUT_SMAX =
    EST_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic signed [EST_W-1:0] OUT_SMIN = ~OUT_SMAX;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_A            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_B            = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRUST_A            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRUST_B            = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 3'd5;

  // Register reset values
  localparam logic [Q_W-1:0] RST_PROCESS_NOISE      = 16'd328;
  localparam logic [Q_W-1:0] RST_NOISE_A            = 16'd328;
  localparam logic [Q_W-1:0] RST_NOISE_B            = 16'd328;
  localparam logic [Q_W-1:0] RST_TRUST_A            = 16'd25887;
  localparam logic [Q_W-1:0] RST_TRUST_B            = 16'd30147;
  localparam logic [Q_W-1:0] RST_INITIAL_COVARIANCE = 16'd32768;

  // Request to the serial multiplier: mcand is signed, mplier unsigned
  typedef struct packed {
    logic               start;
    logic [MC_W-1:0]    mcand;
    logic [MUL_OPW-1:0] mplier;
  } mul_req_t;

  // Request to the serial divider: quotient of num*2^15/den, den >= num
  typedef struct packed {
    logic             start;
    logic [Q_W-1:0]   num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

@@ hdl/tskf_smul.sv @@
// Digit-serial signed by unsigned multiplier, one 4-bit digit of the multiplier per cycle.
module tskf_smul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tskf_pkg::mul_req_t                   req,
  output logic                                 done,
  output logic signed [tskf_pkg::PROD_W-1:0]   prod
);

  localparam int MC_W    = tskf_pkg::MC_W;
  localparam int MUL_OPW = tskf_pkg::MUL_OPW;
  localparam int MUL_DIG = tskf_pkg::MUL_DIG;
  localparam int SUM_W   = MC_W + MUL_DIG + 1;
  localparam int CNT_W   = $clog2(tskf_pkg::MUL_STEPS);

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic signed [MC_W-1:0]   mcand_r;
  logic [MUL_OPW-1:0]       mplier_r;
  logic signed [SUM_W-1:0]  hi;
  logic [MUL_OPW-1:0]       lo;
  logic [MUL_DIG-1:0]       digit;
  logic signed [SUM_W-1:0]  pp;
  logic signed [SUM_W-1:0]  sum;

  // One partial product per cycle, lowest digit first
  assign digit = mplier_r[MUL_DIG-1:0];
  assign pp    = mcand_r * $signed({1'b0, digit});
  assign sum   = hi + pp;
  assign prod  = {hi[MC_W-1:0], lo};

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(tskf_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Accumulate and shift the finished low digits out of the sum
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r  <= $signed(req.mcand);
      mplier_r <= req.mplier;
      hi       <= '0;
      lo       <= '0;
    end else if (busy) begin
      mplier_r <= mplier_r >> MUL_DIG;
      hi       <= sum >>> MUL_DIG;
      lo       <= {sum[MUL_DIG-1:0], lo[MUL_OPW-1:MUL_DIG]};
    end
  end

endmodule

@@ hdl/tskf_sdiv.sv @@
// Bit-serial restoring divider for Kalman gains, one quotient bit per cycle.
module tskf_sdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  tskf_pkg::div_req_t           req,
  output logic                         done,
  output logic [tskf_pkg::Q_W-1:0]     quo
);

  localparam int Q_W       = tskf_pkg::Q_W;
  localparam int DEN_W     = tskf_pkg::DEN_W;
  localparam int DIV_STEPS = tskf_pkg::DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic                  sat;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den_r;
  logic [DIV_STEPS-1:0]  q;
  logic [DEN_W:0]        shifted;
  logic [DEN_W:0]        trial;
  logic                  fits;

  // Trial subtraction of the divisor from the doubled remainder
  assign shifted = {rem, 1'b0};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  // Equal numerator and denominator (zero one included) means a gain of 1.0
  assign quo = sat ? tskf_pkg::ONE_Q15 : Q_W'(q);

  // Step counter and completion pulse; saturated runs take the same time
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder starts at num, since num*2^15 >> 15 is below den
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= DEN_W'(req.num);
      den_r <= req.den;
      sat   <= (req.den == DEN_W'(req.num));
      q     <= '0;
    end else if (busy) begin
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      q   <= {q[DIV_STEPS-2:0], fits};
    end
  end

endmodule

@@ hdl/two_sensor_scalar_kalman_fusion_unit.sv @@
// Top level of the two-sensor scalar Kalman fusion unit: registers, sequencer and datapath.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  sample_a, sample_b
//  m_axis    out        m_axis_tvalid/m_axis_tready  estimate_out, covariance_out
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One item passes from transfer in to the result in the output register through five
// multiply rounds (start, four 4-bit digits, done), one round of two 15-bit serial
// dividers and a write-back state. The input is ready again the cycle after write-back.
// Items are taken one at a time; the next is accepted while the last result waits to transfer.
// A result that cannot enter a full output register holds the sequencer until it can.
// Reset is synchronous: registers return to their reset values, estimate to 0, covariance
// to the initial covariance. The configuration port is always ready.
module two_sensor_scalar_kalman_fusion_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tskf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // sample_a, sample_b
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [tskf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // estimate_out, covariance_out
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tskf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tskf_pkg::Q_W-1:0]              cfg_data
);

  localparam int SAMPLE_W = tskf_pkg::SAMPLE_W;
  localparam int EST_W    = tskf_pkg::EST_W;
  localparam int Q_W      = tskf_pkg::Q_W;
  localparam int FRAC_B   = tskf_pkg::FRAC_B;
  localparam int DEN_W    = tskf_pkg::DEN_W;
  localparam int INNOV_W  = tskf_pkg::INNOV_W;
  localparam int MC_W     = tskf_pkg::MC_W;
  localparam int PROD_W   = tskf_pkg::PROD_W;
  localparam int UPD_W    = PROD_W - FRAC_B;
  localparam int USUM_W   = UPD_W + 1;
  localparam int ESUM_W   = USUM_W + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P_GO   = 4'd1;
  localparam logic [3:0] S_P_WAIT = 4'd2;
  localparam logic [3:0] S_D_GO   = 4'd3;
  localparam logic [3:0] S_D_WAIT = 4'd4;
  localparam logic [3:0] S_G_GO   = 4'd5;
  localparam logic [3:0] S_G_WAIT = 4'd6;
  localparam logic [3:0] S_F_GO   = 4'd7;
  localparam logic [3:0] S_F_WAIT = 4'd8;
  localparam logic [3:0] S_X_GO   = 4'd9;
  localparam logic [3:0] S_X_WAIT = 4'd10;
  localparam logic [3:0] S_C_GO   = 4'd11;
  localparam logic [3:0] S_C_WAIT = 4'd12;
  localparam logic [3:0] S_WB     = 4'd13;

  function automatic logic [Q_W-1:0] factor_of(input logic [Q_W-1:0] p);
    factor_of = (p >= tskf_pkg::ONE_Q15) ? '0 : tskf_pkg::ONE_Q15 - p;
  endfunction

  logic [3:0]                state;
  logic [3:0]                state_next;

  // Configuration registers
  logic [Q_W-1:0]            process_noise;
  logic [Q_W-1:0]            noise_a;
  logic [Q_W-1:0]            noise_b;
  logic [Q_W-1:0]            trust_a;
  logic [Q_W-1:0]            trust_b;
  logic [Q_W-1:0]            initial_covariance;

  // Filter state and per-item working registers
  logic signed [EST_W-1:0]   estimate;
  logic [Q_W-1:0]            covariance;
  logic [Q_W-1:0]            cov_pred;
  logic signed [INNOV_W-1:0] innov_a;
  logic signed [INNOV_W-1:0] innov_b;
  logic signed [UPD_W-1:0]   upd_a;
  logic signed [MC_W-1:0]    cross_b;
  logic [Q_W-1:0]            fac_a;
  logic [Q_W-1:0]            fac_b;
  logic signed [USUM_W-1:0]  upd_sum;
  logic signed [EST_W-1:0]   est_new;

  // Unit requests and results
  tskf_pkg::mul_req_t        mul_req_a;
  tskf_pkg::mul_req_t        mul_req_b;
  tskf_pkg::div_req_t        div_req_a;
  tskf_pkg::div_req_t        div_req_b;
  logic                      mul_done_a;
  logic                      mul_done_b;
  logic signed [PROD_W-1:0]  prod_a;
  logic signed [PROD_W-1:0]  prod_b;
  logic                      div_done_a;
  logic                      div_done_b;
  logic [Q_W-1:0]            gain_a;
  logic [Q_W-1:0]            gain_b;

  // Combinational helpers
  logic                      in_xfer;
  logic                      out_load;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic [Q_W:0]              cov_sum;
  logic signed [ESUM_W-1:0]  est_sum;
  logic                      est_fits;
  logic signed [EST_W-1:0]   est_sat;
  logic signed [EST_W-1:0]   out_shift;
  logic signed [EST_W-1:0]   out_val;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_WB) && (!m_axis_tvalid || m_axis_tready);

  assign sample_a = s_axis_tdata[SAMPLE_W-1:0];
  assign sample_b = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign cov_sum  = {1'b0, covariance} + {1'b0, process_noise};

  // Update the estimate and saturate it to 32 bits
  assign est_sum  = ESUM_W'(estimate) + ESUM_W'(upd_sum);
  assign est_fits = (&est_sum[ESUM_W-1:EST_W-1]) || !(|est_sum[ESUM_W-1:EST_W-1]);
  assign est_sat  = est_fits ? est_sum[EST_W-1:0] :
                    (est_sum[ESUM_W-1] ? $signed({1'b1, {(EST_W-1){1'b0}}}) :
                                         $signed({1'b0, {(EST_W-1){1'b1}}}));

  // Back to Q8.8 and clamp to the sample range
  assign out_shift = est_new >>> tskf_pkg::SAMPLE_SHIFT;
  assign out_val   = (out_shift > tskf_pkg::OUT_SMAX) ? tskf_pkg::OUT_SMAX :
                     (out_shift < tskf_pkg::OUT_SMIN) ? tskf_pkg::OUT_SMIN : out_shift;

  // Select unit operands for each round
  always_comb begin
    mul_req_a = '0;
    mul_req_b = '0;
    div_req_a = '0;
    div_req_b = '0;
    unique case (state)
      S_P_GO: begin
        mul_req_a.start  = 1'b1;
        mul_req_a.mcand  = MC_W'(noise_a);
        mul_req_a.mplier = trust_a;
        mul_req_b.start  = 1'b1;
        mul_req_b.mcand  = MC_W'(noise_b);
        mul_req_b.mplier = trust_b;
      end
      S_D_GO: begin
        div_req_a.start = 1'b1;
        div_req_a.num   = cov_pred;
        div_req_a.den   = DEN_W'(cov_pred) + DEN_W'(prod_a[Q_W+FRAC_B:FRAC_B]);
        div_req_b.start = 1'b1;
        div_req_b.num   = cov_pred;
        div_req_b.den   = DEN_W'(cov_pred) + DEN_W'(prod_b[Q_W+FRAC_B:FRAC_B]);
      end
      S_G_GO: begin
        mul_req_a.start  = 1'b1;
        mul_req_a.mcand  = MC_W'(innov_a);
        mul_req_a.mplier = gain_a;
        mul_req_b.start  = 1'b1;
        mul_req_b.mcand  = MC_W'(innov_b);
        mul_req_b.mplier = gain_b;
      end
      S_F_GO: begin
        mul_req_a.start  = 1'b1;
        mul_req_a.mcand  = MC_W'(gain_a);
        mul_req_a.mplier = trust_a;
        mul_req_b.start  = 1'b1;
        mul_req_b.mcand  = MC_W'(gain_b);
        mul_req_b.mplier = trust_b;
      end
      S_X_GO: begin
        mul_req_a.start  = 1'b1;
        mul_req_a.mcand  = cross_b;
        mul_req_a.mplier = trust_b;
        mul_req_b.start  = 1'b1;
        mul_req_b.mcand  = MC_W'(fac_a);
        mul_req_b.mplier = fac_b;
      end
      S_C_GO: begin
        mul_req_a.start  = 1'b1;
        mul_req_a.mcand  = MC_W'(prod_b[Q_W+FRAC_B-1:FRAC_B]);
        mul_req_a.mplier = cov_pred;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_xfer) state_next = S_P_GO;
      S_P_GO:   state_next = S_P_WAIT;
      S_P_WAIT: if (mul_done_a && mul_done_b) state_next = S_D_GO;
      S_D_GO:   state_next = S_D_WAIT;
      S_D_WAIT: if (div_done_a && div_done_b) state_next = S_G_GO;
      S_G_GO:   state_next = S_G_WAIT;
      S_G_WAIT: if (mul_done_a && mul_done_b) state_next = S_F_GO;
      S_F_GO:   state_next = S_F_WAIT;
      S_F_WAIT: if (mul_done_a && mul_done_b) state_next = S_X_GO;
      S_X_GO:   state_next = S_X_WAIT;
      S_X_WAIT: if (mul_done_a && mul_done_b) state_next = S_C_GO;
      S_C_GO:   state_next = S_C_WAIT;
      S_C_WAIT: if (mul_done_a) state_next = S_WB;
      S_WB:     if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state, filter state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      estimate      <= '0;
      covariance    <= tskf_pkg::RST_INITIAL_COVARIANCE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        estimate      <= est_new;
        covariance    <= prod_a[Q_W+FRAC_B-1:FRAC_B];
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= tskf_pkg::RST_PROCESS_NOISE;
      noise_a            <= tskf_pkg::RST_NOISE_A;
      noise_b            <= tskf_pkg::RST_NOISE_B;
      trust_a            <= tskf_pkg::RST_TRUST_A;
      trust_b            <= tskf_pkg::RST_TRUST_B;
      initial_covariance <= tskf_pkg::RST_INITIAL_COVARIANCE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tskf_pkg::REG_PROCESS_NOISE:      process_noise      <= cfg_data;
        tskf_pkg::REG_NOISE_A:            noise_a            <= cfg_data;
        tskf_pkg::REG_NOISE_B:            noise_b            <= cfg_data;
        tskf_pkg::REG_TRUST_A:            trust_a            <= cfg_data;
        tskf_pkg::REG_TRUST_B:            trust_b            <= cfg_data;
        tskf_pkg::REG_INITIAL_COVARIANCE: initial_covariance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Working registers, loaded when an item is accepted and as each round finishes
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cov_pred <= cov_sum[Q_W] ? {Q_W{1'b1}} : cov_sum[Q_W-1:0];
          innov_a  <= (INNOV_W'(sample_a) <<< tskf_pkg::SAMPLE_SHIFT) - INNOV_W'(estimate);
          innov_b  <= (INNOV_W'(sample_b) <<< tskf_pkg::SAMPLE_SHIFT) - INNOV_W'(estimate);
        end
      end
      S_G_WAIT: begin
        if (mul_done_a) upd_a   <= prod_a[PROD_W-1:FRAC_B];
        if (mul_done_b) cross_b <= prod_b[FRAC_B+MC_W-1:FRAC_B];
      end
      S_F_WAIT: begin
        if (mul_done_a) fac_a <= factor_of(prod_a[Q_W+FRAC_B-1:FRAC_B]);
        if (mul_done_b) fac_b <= factor_of(prod_b[Q_W+FRAC_B-1:FRAC_B]);
      end
      S_X_WAIT: begin
        if (mul_done_a) begin
          upd_sum <= USUM_W'(upd_a) + USUM_W'($signed(prod_a[PROD_W-1:FRAC_B]));
        end
      end
      S_C_GO: begin
        est_new <= est_sat;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {prod_a[Q_W+FRAC_B-1:FRAC_B], out_val[Q_W-1:0]};
    end
  end

  tskf_smul u_mul_a (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req_a),
    .done (mul_done_a),
    .prod (prod_a)
  );

  tskf_smul u_mul_b (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req_b),
    .done (mul_done_b),
    .prod (prod_b)
  );

  tskf_sdiv u_div_a (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req_a),
    .done (div_done_a),
    .quo  (gain_a)
  );

  tskf_sdiv u_div_b (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req_b),
    .done (div_done_b),
    .quo  (gain_b)
  );

  // An accepted item starts the first multiply round
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_P_GO)
    else $error("accepted item did not start the multiply round");

  // Both gain dividers finish together, and only while the sequencer waits on them
  assert property (@(posedge clk) disable iff (rst)
    (div_done_a || div_done_b) |-> (div_done_a && div_done_b && state == S_D_WAIT))
    else $error("gain dividers out of step with the sequencer");

  // Results of the first multiplier arrive only in a wait state
  assert property (@(posedge clk) disable iff (rst)
    mul_done_a |-> (state == S_P_WAIT || state == S_G_WAIT || state == S_F_WAIT ||
                    state == S_X_WAIT || state == S_C_WAIT))
    else $error("multiplier result outside a wait state");

  // Covariance factors never exceed 1.0
  assert property (@(posedge clk) disable iff (rst)
    state == S_X_GO |-> (fac_a <= tskf_pkg::ONE_Q15 && fac_b <= tskf_pkg::ONE_Q15))
    else $error("covariance factor above 1.0");

  // A write-back into a free output register presents the result and frees the input
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tvalid && state == S_IDLE))
    else $error("write-back did not present the result");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench of the two-sensor scalar Kalman fusion unit.
`timescale 1ns / 1ps

import tskf_pkg::*;

// Tracks the filter state and configuration, predicts each result and checks it in order
class kalman_tracker;
  int unsigned reg_val[6];
  longint      estimate;
  longint      covariance;
  logic [31:0] expected_outputs[$];
  int          mismatches;

  function new();
    reg_val[REG_PROCESS_NOISE]      = RST_PROCESS_NOISE;
    reg_val[REG_NOISE_A]            = RST_NOISE_A;
    reg_val[REG_NOISE_B]            = RST_NOISE_B;
    reg_val[REG_TRUST_A]            = RST_TRUST_A;
    reg_val[REG_TRUST_B]            = RST_TRUST_B;
    reg_val[REG_INITIAL_COVARIANCE] = RST_INITIAL_COVARIANCE;
    estimate   = 0;
    covariance = RST_INITIAL_COVARIANCE;
    mismatches = 0;
  endfunction

  // Drop writes to indexes past the last register
  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    if (idx <= REG_INITIAL_COVARIANCE) reg_val[idx] = value;
  endfunction

  // Gain of one sensor; an empty denominator means full gain
  function longint sensor_gain(longint cov, longint noise, longint trust);
    longint den, g;
    den = cov + ((noise * trust) >> 15);
    if (den == 0) return 32768;
    g = (cov << 15) / den;
    return (g > 32768) ? 32768 : g;
  endfunction

  // Covariance shrink factor of one sensor, clamped at zero
  function longint shrink_factor(longint gain, longint trust);
    longint p;
    p = (gain * trust) >> 15;
    return (p >= 32768) ? 0 : 32768 - p;
  endfunction

  // Advance the filter by one accepted sample pair and queue the result
  function void fuse_samples(logic [15:0] a_bits, logic [15:0] b_bits);
    localparam longint EST_MAX = 2147483647;
    localparam longint EST_MIN = -EST_MAX - 1;
    longint q, na, nb, ta, tb, sa, sb;
    longint cv, ga, gb, ya, yb, upd, est, pn, eo;
    q  = reg_val[REG_PROCESS_NOISE];
    na = reg_val[REG_NOISE_A];
    nb = reg_val[REG_NOISE_B];
    ta = reg_val[REG_TRUST_A];
    tb = reg_val[REG_TRUST_B];
    sa = $signed(a_bits);
    sb = $signed(b_bits);

    // predict
    cv = covariance + q;
    if (cv > 65535) cv = 65535;
    ga = sensor_gain(cv, na, ta);
    gb = sensor_gain(cv, nb, tb);

    // update estimate, floor shifts throughout
    ya  = sa * 256 - estimate;
    yb  = sb * 256 - estimate;
    upd = (ga * ya) >>> 15;
    upd = upd + ((((gb * yb) >>> 15) * tb) >>> 15);
    est = estimate + upd;
    if (est > EST_MAX) est = EST_MAX;
    if (est < EST_MIN) est = EST_MIN;

    // update covariance
    pn = (((shrink_factor(ga, ta) * shrink_factor(gb, tb)) >> 15) * cv) >> 15;
    if (pn > 65535) pn = 65535;

    eo = est >>> 8;
    if (eo > 32767) eo = 32767;
    if (eo < -32768) eo = -32768;

    estimate   = est;
    covariance = pn;
    expected_outputs.push_back({pn[15:0], eo[15:0]});
  endfunction

  // Compare one output transfer with the oldest prediction
  function void compare_output(logic [31:0] tdata);
    logic [31:0] want;
    if (expected_outputs.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected, actual %h", $time, tdata);
      return;
    end
    want = expected_outputs.pop_front();
    if (tdata[15:0] !== want[15:0]) begin
      mismatches++;
      $display("%0t: estimate_out expected %0d actual %0d", $time,
               $signed(want[15:0]), $signed(tdata[15:0]));
    end
    if (tdata[31:16] !== want[31:16]) begin
      mismatches++;
      $display("%0t: covariance_out expected %0d actual %0d", $time,
               want[31:16], tdata[31:16]);
    end
  endfunction
endclass

module tb_top;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 183;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // sample_a, sample_b
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // estimate_out, covariance_out
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [Q_W-1:0]         cfg_data      = '0;

  kalman_tracker tracker = new();
  int send_idle_pct = 10;
  int recv_idle_pct = 68;
  int results_seen  = 0;

  two_sensor_scalar_kalman_fusion_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Drive output ready; hold off once for a long stretch so the block backs up
  initial begin : output_ready
    int hold_left = 0;
    bit held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= 150) begin
        held_once = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check each output transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tracker.compare_output(m_axis_tdata);
      results_seen <= results_seen + 1;
    end
  end

  // Offer one sample pair after a random gap and hold it until the transfer
  task automatic send_samples(input logic [15:0] a, input logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, a};
    do @(posedge clk); while (!s_axis_tready);
    tracker.fuse_samples(a, b);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] pnoise, input logic [15:0] na,
                               input logic [15:0] nb, input logic [15:0] ta,
                               input logic [15:0] tb, input logic [15:0] icov);
    write_register(REG_PROCESS_NOISE, pnoise);
    write_register(REG_NOISE_A, na);
    write_register(REG_NOISE_B, nb);
    write_register(REG_TRUST_A, ta);
    write_register(REG_TRUST_B, tb);
    write_register(REG_INITIAL_COVARIANCE, icov);
  endtask

  // Stop offering and wait until every predicted result has transferred
  task automatic wait_drained;
    s_axis_tvalid = 1'b0;
    while (tracker.expected_outputs.size() != 0) @(negedge clk);
  endtask

  // Register value biased toward the extremes; trust mostly stays within 1.0
  function automatic logic [15:0] pick_value(input bit is_trust);
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return is_trust ? ONE_Q15 : 16'hFFFF;
      2: return is_trust ? 16'($urandom_range(65535, 32769)) : 16'h0001;
      default: return is_trust ? 16'($urandom_range(32768)) : 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin : stimulus
    int p, k, track;
    logic [15:0] a, b;
    track = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // extremes of both samples at reset settings
    send_samples(16'h0000, 16'h0000);
    send_samples(16'h7FFF, 16'h7FFF);
    send_samples(16'h8000, 16'h8000);
    send_samples(16'h7FFF, 16'h8000);
    send_samples(16'h8000, 16'h7FFF);
    send_samples(16'h5555, 16'hAAAA);
    send_samples(16'hFFFF, 16'h0001);
    wait_drained;

    // no noise, full trust, no process noise: covariance collapses, then zero denominators;
    // writes to unused indexes must be ignored
    load_settings(16'h0000, 16'h0000, 16'h0000, ONE_Q15, ONE_Q15, 16'h0000);
    write_register(REG_SPARE_6, 16'hFFFF);
    write_register(REG_SPARE_7, 16'h1234);
    send_samples(16'h0100, 16'h0200);
    send_samples(16'h8000, 16'h7FFF);
    send_samples(16'h0001, 16'hFFFF);
    send_samples(16'h1234, 16'h4321);
    wait_drained;

    // trust above 1.0 clamps the factors, prediction saturates the covariance,
    // alternating full-scale samples drive the estimate into saturation
    load_settings(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (k = 0; k < 10; k++) begin
      a = k[0] ? 16'h7FFF : 16'h8000;
      send_samples(a, a);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained;
      if (p == 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 10;
      end
      if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) begin
        load_settings(RST_PROCESS_NOISE, RST_NOISE_A, RST_NOISE_B, RST_TRUST_A, RST_TRUST_B,
                      RST_INITIAL_COVARIANCE);
      end else if (p == 1) begin
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end else begin
        load_settings(pick_value(1'b0), pick_value(1'b0), pick_value(1'b0),
                      pick_value(1'b1), pick_value(1'b1), pick_value(1'b0));
      end
      if ($urandom_range(2) == 0)
        write_register($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ($urandom_range(7))
          0, 1: begin
            a = 16'($urandom);
            b = 16'($urandom);
          end
          2: begin
            a = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            b = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          end
          default: begin
            // slowly moving target seen by both sensors with small noise
            track = track + $urandom_range(64) - 32;
            if (track > 30000) track = 30000;
            if (track < -30000) track = -30000;
            a = 16'(track + $urandom_range(16) - 8);
            b = 16'(track + $urandom_range(16) - 8);
          end
        endcase
        send_samples(a, b);
      end
    end

    wait_drained;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
